### hw/rtl/aatc_pkg.sv
package aatc_pkg;

    // Table geometry.
    localparam int TABLE_ENTRIES_DEF = 16;
    localparam int ENTRIES_MAX       = 64;
    localparam int FIRST_IDX_W       = 6;
    localparam int FIRST_W           = FIRST_IDX_W + 1;

    // Field widths.
    localparam int ADDR_W   = 48;
    localparam int TIME_W   = 32;
    localparam int EXPIRY_W = 24;
    localparam int ENTRY_W  = ADDR_W + TIME_W;

    localparam logic [EXPIRY_W-1:0] EXPIRY_RESET = 24'd10000;

    // Request kinds.
    localparam logic [2:0] KIND_REFRESH = 3'd0;
    localparam logic [2:0] KIND_SEEN    = 3'd1;
    localparam logic [2:0] KIND_UP      = 3'd2;
    localparam logic [2:0] KIND_DOWN    = 3'd3;
    localparam logic [2:0] KIND_SELECT  = 3'd4;
    localparam logic [2:0] KIND_OTHER   = 3'd5;

    // Name check codes.
    localparam logic [1:0] NAME_OK      = 2'd0;
    localparam logic [1:0] NAME_MISSING = 2'd1;

    // Result status codes.
    localparam logic [1:0] STATUS_OK          = 2'd0;
    localparam logic [1:0] STATUS_INVALID_ARG = 2'd1;
    localparam logic [1:0] STATUS_NAME_SIZE   = 2'd2;
    localparam logic [1:0] STATUS_UNUSED      = 2'd3;

    typedef struct packed {
        logic [2:0]        kind;
        logic [ADDR_W-1:0] device_address;
        logic [1:0]        name_check;
        logic [TIME_W-1:0] now_ms;
    } aatc_req_t;

    typedef struct packed {
        logic [1:0]        status;
        logic              cursor_valid;
        logic [3:0]        cursor_index;
        logic [4:0]        entry_count;
        logic              connect_request;
        logic [ADDR_W-1:0] connect_address;
    } aatc_rsp_t;

    // Verdict of the per-entry compare unit.
    typedef struct packed {
        logic expired;
        logic hit;
    } aatc_scan_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SWEEP,
        ST_INSERT,
        ST_BUTTON,
        ST_WALK,
        ST_FETCH,
        ST_REPORT
    } aatc_state_t;

    // Lowest set bit: {found, index}. Index is zero when nothing is set.
    function automatic logic [FIRST_W-1:0] aatc_first(input logic [ENTRIES_MAX-1:0] vec);
        logic                   found;
        logic [FIRST_IDX_W-1:0] idx;
        found = 1'b0;
        idx   = '0;
        for (int i = ENTRIES_MAX - 1; i >= 0; i--)
        begin
            if (vec[i])
            begin
                found = 1'b1;
                idx   = FIRST_IDX_W'(i);
            end
        end
        return {found, idx};
    endfunction

endpackage

### hw/rtl/aatc_ram.sv
module aatc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### hw/rtl/aatc_scan.sv
module aatc_scan (
    input  logic                         entry_valid,
    input  logic [aatc_pkg::ENTRY_W-1:0] entry_data,
    input  logic [aatc_pkg::EXPIRY_W-1:0] expiry_ms,
    input  logic [aatc_pkg::TIME_W-1:0]  now_ms,
    input  logic [aatc_pkg::ADDR_W-1:0]  target_address,
    output aatc_pkg::aatc_scan_t         verdict
);
    import aatc_pkg::*;

    logic [ADDR_W-1:0] entry_address;
    logic [TIME_W-1:0] entry_seen;
    logic [TIME_W:0]   deadline;

    assign entry_address = entry_data[ENTRY_W-1 -: ADDR_W];
    assign entry_seen    = entry_data[TIME_W-1:0];

    // The deadline carries one extra bit so the sum cannot overflow.
    assign deadline = {1'b0, entry_seen} + (TIME_W + 1)'(expiry_ms);

    always_comb
    begin
        verdict.expired = entry_valid && (deadline < {1'b0, now_ms});
        verdict.hit     = entry_valid && !verdict.expired && (entry_address == target_address);
    end

endmodule

### hw/rtl/aging_address_table_cursor_core.sv
// Refresh and device-seen requests sweep every slot; device seen with an accepted name
// then inserts. Buttons snap the cursor; up and down then walk past invalid slots and
// select fetches the entry. Unused kinds go straight to the report.
// The sweep reads one entry per cycle from the entry memory. One request
// is in flight at a time; busy drops in the cycle done is shown, so requests can follow.
// Reset empties the table, unsets the cursor and loads an expiry of 10000 ms.
module aging_address_table_cursor_core #(
    parameter int TABLE_ENTRIES = aatc_pkg::TABLE_ENTRIES_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  aatc_pkg::aatc_req_t             request,
    output logic                            busy,
    output logic                            done,
    output aatc_pkg::aatc_rsp_t             result,
    input  logic                            cfg_we,
    input  logic [aatc_pkg::EXPIRY_W-1:0]   cfg_data
);
    import aatc_pkg::*;

    localparam int IDX_W = $clog2(TABLE_ENTRIES);
    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(TABLE_ENTRIES);

    aatc_state_t               state_reg, state_next;
    logic [EXPIRY_W-1:0]       expiry_reg;
    aatc_req_t                 req_reg, req_next;
    logic [TABLE_ENTRIES-1:0]  valid_reg, valid_next;
    logic [CNT_W-1:0]          count_reg, count_next;
    logic                      cur_set_reg, cur_set_next;
    logic [IDX_W-1:0]          cur_pos_reg, cur_pos_next;
    logic [IDX_W-1:0]          walk_pos_reg, walk_pos_next;
    logic [CNT_W-1:0]          scan_cnt_reg, scan_cnt_next;
    logic                      pend_reg, pend_next;
    logic [IDX_W-1:0]          pend_idx_reg, pend_idx_next;
    logic                      hit_found_reg, hit_found_next;
    logic [IDX_W-1:0]          hit_idx_reg, hit_idx_next;
    logic                      done_reg, done_next;
    aatc_rsp_t                 rsp_reg, rsp_next;

    logic                      accept;
    logic                      ram_we;
    logic [IDX_W-1:0]          ram_waddr;
    logic [ENTRY_W-1:0]        ram_wdata;
    logic [IDX_W-1:0]          ram_raddr;
    logic [ENTRY_W-1:0]        ram_rdata;
    aatc_scan_t                scan;
    logic                      sweep_drop;
    logic [TABLE_ENTRIES-1:0]  drop_mask;
    logic [FIRST_W-1:0]        first_valid;
    logic [FIRST_W-1:0]        first_free;
    logic [IDX_W-1:0]          first_valid_idx;
    logic [IDX_W-1:0]          first_free_idx;
    logic [IDX_W-1:0]          pos_inc;
    logic [IDX_W-1:0]          pos_dec;
    logic [IDX_W-1:0]          step_pos;
    logic                      walk_end;
    logic                      sweep_last;
    logic [1:0]                status_code;

    assign busy   = (state_reg != ST_IDLE);
    assign accept = start && !busy;
    assign done   = done_reg;
    assign result = rsp_reg;

    // Entry memory: address and last-seen time per slot.
    aatc_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(TABLE_ENTRIES)
    ) u_entry_ram (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    // Age and address compare for the entry that the sweep has just read.
    aatc_scan u_scan (
        .entry_valid   (valid_reg[pend_idx_reg]),
        .entry_data    (ram_rdata),
        .expiry_ms     (expiry_reg),
        .now_ms        (req_reg.now_ms),
        .target_address(req_reg.device_address),
        .verdict       (scan)
    );

    // Slot cleared by the sweep in this cycle, if any.
    assign sweep_drop = (state_reg == ST_SWEEP) && pend_reg && scan.expired;
    assign drop_mask  = sweep_drop ? (TABLE_ENTRIES'(1) << pend_idx_reg) : '0;

    // First valid slot (after a drop in this cycle) and first free slot.
    assign first_valid     = aatc_first(ENTRIES_MAX'(valid_reg & ~drop_mask));
    assign first_free      = aatc_first(ENTRIES_MAX'(~valid_reg));
    assign first_valid_idx = first_valid[IDX_W-1:0];
    assign first_free_idx  = first_free[IDX_W-1:0];

    // Cyclic neighbors of the walk position.
    assign pos_inc  = (walk_pos_reg == LAST_IDX) ? '0 : walk_pos_reg + 1'b1;
    assign pos_dec  = (walk_pos_reg == '0) ? LAST_IDX : walk_pos_reg - 1'b1;
    assign step_pos = (req_reg.kind == KIND_UP) ? pos_dec : pos_inc;
    assign walk_end = !cur_set_reg || (count_reg == '0) || valid_reg[step_pos];

    assign sweep_last = pend_reg && (pend_idx_reg == LAST_IDX);

    // Status of the finished request.
    always_comb
    begin
        status_code = STATUS_OK;
        if (req_reg.kind == KIND_SEEN)
        begin
            case (req_reg.name_check)
                NAME_OK:      status_code = STATUS_OK;
                NAME_MISSING: status_code = STATUS_INVALID_ARG;
                default:      status_code = STATUS_NAME_SIZE;
            endcase
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (request.kind) inside
                        KIND_REFRESH, KIND_SEEN:                     state_next = ST_SWEEP;
                        KIND_UP, KIND_DOWN, KIND_SELECT, KIND_OTHER: state_next = ST_BUTTON;
                        default:                                     state_next = ST_REPORT;
                    endcase
                end
            end
            ST_SWEEP:
            begin
                if (sweep_last)
                begin
                    if ((req_reg.kind == KIND_SEEN) && (req_reg.name_check == NAME_OK))
                    begin
                        state_next = ST_INSERT;
                    end
                    else
                    begin
                        state_next = ST_REPORT;
                    end
                end
            end
            ST_INSERT:
            begin
                state_next = ST_REPORT;
            end
            ST_BUTTON:
            begin
                case (req_reg.kind) inside
                    KIND_UP, KIND_DOWN: state_next = ST_WALK;
                    KIND_SELECT:        state_next = ST_FETCH;
                    default:            state_next = ST_REPORT;
                endcase
            end
            ST_WALK:
            begin
                if (walk_end)
                begin
                    state_next = ST_REPORT;
                end
            end
            ST_FETCH:
            begin
                state_next = ST_REPORT;
            end
            ST_REPORT:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Datapath and memory control for each state.
    always_comb
    begin
        req_next       = req_reg;
        valid_next     = valid_reg;
        count_next     = count_reg;
        cur_set_next   = cur_set_reg;
        cur_pos_next   = cur_pos_reg;
        walk_pos_next  = walk_pos_reg;
        scan_cnt_next  = scan_cnt_reg;
        pend_next      = 1'b0;
        pend_idx_next  = pend_idx_reg;
        hit_found_next = hit_found_reg;
        hit_idx_next   = hit_idx_reg;
        done_next      = 1'b0;
        rsp_next       = rsp_reg;
        ram_we         = 1'b0;
        ram_waddr      = hit_found_reg ? hit_idx_reg : first_free_idx;
        ram_wdata      = {req_reg.device_address, req_reg.now_ms};
        ram_raddr      = scan_cnt_reg[IDX_W-1:0];

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    req_next       = request;
                    scan_cnt_next  = '0;
                    hit_found_next = 1'b0;
                end
            end
            ST_SWEEP:
            begin
                // Issue the next read while judging the entry read last cycle.
                if (scan_cnt_reg < FULL_CNT)
                begin
                    pend_next     = 1'b1;
                    pend_idx_next = scan_cnt_reg[IDX_W-1:0];
                    scan_cnt_next = scan_cnt_reg + 1'b1;
                end
                if (pend_reg)
                begin
                    if (scan.expired)
                    begin
                        valid_next = valid_reg & ~drop_mask;
                        if (count_reg != '0)
                        begin
                            count_next = count_reg - 1'b1;
                        end
                        if (cur_set_reg && (cur_pos_reg == pend_idx_reg))
                        begin
                            cur_set_next = first_valid[FIRST_W-1];
                            cur_pos_next = first_valid_idx;
                        end
                    end
                    else if (scan.hit && !hit_found_reg)
                    begin
                        hit_found_next = 1'b1;
                        hit_idx_next   = pend_idx_reg;
                    end
                end
            end
            ST_INSERT:
            begin
                // Refresh a known address, or fill the first free slot if the table has room.
                if (hit_found_reg)
                begin
                    ram_we = 1'b1;
                end
                else if (count_reg < FULL_CNT)
                begin
                    ram_we     = 1'b1;
                    valid_next = valid_reg | (TABLE_ENTRIES'(1) << first_free_idx);
                    count_next = count_reg + 1'b1;
                    if (!cur_set_reg)
                    begin
                        cur_set_next = 1'b1;
                        cur_pos_next = first_free_idx;
                    end
                end
            end
            ST_BUTTON:
            begin
                // Snap an unset or stale cursor to the first valid slot.
                if (!cur_set_reg || !valid_reg[cur_pos_reg])
                begin
                    cur_set_next  = first_valid[FIRST_W-1];
                    cur_pos_next  = first_valid_idx;
                    walk_pos_next = first_valid_idx;
                end
                else
                begin
                    walk_pos_next = cur_pos_reg;
                end
            end
            ST_WALK:
            begin
                // One slot per cycle in the chosen direction.
                if (!cur_set_reg || (count_reg == '0))
                begin
                    cur_set_next = 1'b0;
                    cur_pos_next = '0;
                end
                else if (valid_reg[step_pos])
                begin
                    cur_pos_next = step_pos;
                end
                else
                begin
                    walk_pos_next = step_pos;
                end
            end
            ST_FETCH:
            begin
                ram_raddr = cur_pos_reg;
            end
            ST_REPORT:
            begin
                done_next                = 1'b1;
                rsp_next.status          = status_code;
                rsp_next.cursor_valid    = cur_set_reg;
                rsp_next.cursor_index    = cur_set_reg ? 4'(cur_pos_reg) : 4'd0;
                rsp_next.entry_count     = 5'(count_reg);
                rsp_next.connect_request = (req_reg.kind == KIND_SELECT) && cur_set_reg;
                rsp_next.connect_address = rsp_next.connect_request ?
                                           ram_rdata[ENTRY_W-1 -: ADDR_W] : '0;
            end
            default:
            begin
                done_next = 1'b0;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            expiry_reg    <= EXPIRY_RESET;
            valid_reg     <= '0;
            count_reg     <= '0;
            cur_set_reg   <= 1'b0;
            cur_pos_reg   <= '0;
            scan_cnt_reg  <= '0;
            pend_reg      <= 1'b0;
            hit_found_reg <= 1'b0;
            done_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            valid_reg     <= valid_next;
            count_reg     <= count_next;
            cur_set_reg   <= cur_set_next;
            cur_pos_reg   <= cur_pos_next;
            scan_cnt_reg  <= scan_cnt_next;
            pend_reg      <= pend_next;
            hit_found_reg <= hit_found_next;
            done_reg      <= done_next;
            if (cfg_we)
            begin
                expiry_reg <= cfg_data;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        req_reg      <= req_next;
        walk_pos_reg <= walk_pos_next;
        pend_idx_reg <= pend_idx_next;
        hit_idx_reg  <= hit_idx_next;
        rsp_reg      <= rsp_next;
    end

endmodule

### hw/rtl/aatc_checker.sv
module aatc_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                start,
    input logic                busy,
    input logic                done,
    input aatc_pkg::aatc_rsp_t result
);
    import aatc_pkg::*;

    // An accepted request keeps the block busy in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("accepted request did not raise busy");

    // No selection means a zero cursor index.
    assert property (@(posedge clk) disable iff (!rst_n)
        done && !result.cursor_valid |-> result.cursor_index == 4'd0)
        else $error("cursor index set without a selection");

    // A connect request needs a selected entry; otherwise the address is zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        done && result.connect_request |-> result.cursor_valid)
        else $error("connect request without a selection");

    assert property (@(posedge clk) disable iff (!rst_n)
        done && !result.connect_request |-> result.connect_address == '0)
        else $error("connect address set without a connect request");

    // The status never takes the unused code.
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> result.status != STATUS_UNUSED)
        else $error("unused status code reported");

endmodule

bind aging_address_table_cursor_core aatc_checker u_aatc_checker (.*);
